>>> rtl/core/b2d_pkg.sv
`default_nettype none

package b2d_pkg;

   localparam int VALUE_W    = 32;
   localparam int NIB_W      = 4;
   localparam int NUM_BCD    = 10;
   localparam int BCD_W      = NUM_BCD * NIB_W;
   localparam int IDX_W      = 4;
   localparam int CHAR_W     = 6;
   localparam int CNT_W      = 5;

   localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;
   localparam logic [CNT_W-1:0]  LAST_BIT   = 5'd31;

   typedef struct packed {
      logic load;
      logic shift;
      logic set_idx;
      logic step_idx;
   } b2d_cmd_type;

   typedef struct packed {
      logic idx_zero;
   } b2d_sts_type;

endpackage

`default_nettype wire

>>> rtl/core/b2d_if.sv
`default_nettype none

interface b2d_req_if import b2d_pkg::*;;
   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

interface b2d_rsp_if import b2d_pkg::*;;
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] digit_char;
   logic              last_digit;

   modport source (output valid, output digit_char, output last_digit, input ready);
   modport sink   (input valid, input digit_char, input last_digit, output ready);
endinterface

`default_nettype wire

>>> rtl/core/b2d_datapath.sv
`default_nettype none

module b2d_datapath import b2d_pkg::*; #(
   parameter int MAX_DIGITS = 10
) (
   input  wire logic               clock,
   input  wire b2d_cmd_type        cmd,
   output b2d_sts_type             sts,
   input  wire logic [VALUE_W-1:0] value,
   output logic      [CHAR_W-1:0]  digit_char,
   output logic                    last_digit
);

   localparam int LIMIT = (MAX_DIGITS < 1) ? 1 :
                          ((MAX_DIGITS < NUM_BCD) ? MAX_DIGITS : NUM_BCD);

   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [BCD_W-1:0]   bcd_ff, bcd_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [BCD_W-1:0]   adj;
   logic [IDX_W-1:0]   top_idx;
   logic [NIB_W-1:0]   nibble;

   // Shift-and-add-3: every BCD digit of five or more is corrected before the shift.
   always_comb begin
      for (int i = 0; i < NUM_BCD; i++) begin
         if (bcd_ff[i*NIB_W +: NIB_W] >= 4'd5) begin
            adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W] + 4'd3;
         end else begin
            adj[i*NIB_W +: NIB_W] = bcd_ff[i*NIB_W +: NIB_W];
         end
      end
   end

   // Highest nonzero digit; zero still yields one digit. A nonzero digit beyond
   // the buffer limit means the full buffer is sent, leading zeros included.
   always_comb begin
      top_idx = '0;
      for (int i = 1; i < NUM_BCD; i++) begin
         if (bcd_ff[i*NIB_W +: NIB_W] != '0) begin
            top_idx = (i < LIMIT) ? IDX_W'(i) : IDX_W'(LIMIT - 1);
         end
      end
   end

   always_comb begin
      shift_in = shift_ff;
      bcd_in   = bcd_ff;
      idx_in   = idx_ff;
      if (cmd.load) begin
         shift_in = value;
         bcd_in   = '0;
      end else if (cmd.shift) begin
         shift_in = {shift_ff[VALUE_W-2:0], 1'b0};
         bcd_in   = {adj[BCD_W-2:0], shift_ff[VALUE_W-1]};
      end
      if (cmd.set_idx) begin
         idx_in = top_idx;
      end else if (cmd.step_idx) begin
         idx_in = idx_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      bcd_ff   <= bcd_in;
      idx_ff   <= idx_in;
   end

   assign nibble       = bcd_ff[{idx_ff, 2'b00} +: NIB_W];
   assign digit_char   = ASCII_ZERO + {2'b00, nibble};
   assign last_digit   = (idx_ff == '0);
   assign sts.idx_zero = (idx_ff == '0);

endmodule

`default_nettype wire

>>> rtl/core/b2d_ctrl.sv
`default_nettype none

module b2d_ctrl import b2d_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output b2d_cmd_type      cmd,
   input  wire b2d_sts_type sts
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_SCAN = 2'd2;
   localparam logic [1:0] ST_EMIT = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic             req_fire, rsp_fire;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid && rsp_ready;

   always_comb begin
      state_in     = state_ff;
      bit_cnt_in   = bit_cnt_ff;
      cmd          = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.load   = req_fire;
            bit_cnt_in = '0;
            if (req_fire) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.shift  = 1'b1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.set_idx = 1'b1;
            state_in    = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_fire) begin
               if (sts.idx_zero) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.step_idx = 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == ST_CONV && bit_cnt_ff == '0))
      else $error("accepted word did not start conversion");

   a_conv_length: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV && bit_cnt_ff == LAST_BIT) |=> state_ff == ST_SCAN)
      else $error("conversion did not end after 32 shifts");

   a_last_word_ends_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && sts.idx_zero) |=> state_ff == ST_IDLE)
      else $error("run did not end after the last digit");

   a_step_only_on_fire: assert property (@(posedge clock) disable iff (reset)
      cmd.step_idx |-> (rsp_fire && !sts.idx_zero))
      else $error("digit index moved without a delivered word");

endmodule

`default_nettype wire

>>> rtl/core/binary_to_decimal_ascii_core.sv
`default_nettype none
// Binary to decimal ASCII converter.
// The req_chan channel carries one unsigned 32-bit value per word. The rsp_chan
// channel returns its decimal digits as ASCII characters, most significant first,
// without leading zeros; zero gives a single '0'. last_digit marks the final
// character of a value. If MAX_DIGITS is below the digit count, only the low
// MAX_DIGITS digits are sent.
// A value is converted by a shift-and-add-3 unit, one input bit per cycle. Once
// every input bit is shifted in, a scan state finds the leading digit and the
// first character is presented. Each further character is presented in the cycle
// after the previous one is taken. One value is handled at a time; req_chan.ready
// returns in the cycle after the last character is taken.
// When the receiver stalls, the current character holds steady and the input
// stays closed. Synchronous reset returns the block to idle, ready for a value,
// and drops any run in progress.
module binary_to_decimal_ascii_core import b2d_pkg::*; #(
   parameter int MAX_DIGITS = 10
) (
   input wire logic clock,
   input wire logic reset,
   b2d_req_if.sink  req_chan,
   b2d_rsp_if.source rsp_chan
);

   b2d_cmd_type cmd;
   b2d_sts_type sts;

   b2d_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   b2d_datapath #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_datapath (
      .clock      (clock),
      .cmd        (cmd),
      .sts        (sts),
      .value      (req_chan.value),
      .digit_char (rsp_chan.digit_char),
      .last_digit (rsp_chan.last_digit)
   );

endmodule

`default_nettype wire

>>> dv/testbench.sv
module testbench import b2d_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DIGIT_LIMIT = 10;
   localparam int MAX_IDLE    = 2000;
   localparam int LONG_HOLD   = 300;
   localparam int HOLD_AFTER  = 120;
   localparam int DRAIN_WAIT  = 60;
   localparam int RANDOM_VALUES = 500;
   localparam int PRINT_CAP   = 30;

   class decimal_scoreboard;
      typedef struct packed {
         logic [CHAR_W-1:0] digit_char;
         logic              last_digit;
      } ascii_digit_type;

      ascii_digit_type pending_digits[$];
      int errors;
      int values_seen;
      int chars_checked;
      int per_length[0:DIGIT_LIMIT];

      task report(input string what);
         errors++;
         if (errors <= PRINT_CAP) begin
            $display("ERROR at %0t ns: %s", $time, what);
         end
      endtask

      // Splits the value into decimal digits and queues their characters,
      // most significant first; the digit buffer size cuts off high digits.
      task note_value(input logic [VALUE_W-1:0] v);
         logic [3:0]         digits[$];
         logic [VALUE_W-1:0] rest;
         int                 lim;
         int                 n;
         ascii_digit_type    d;
         rest = v;
         lim  = (DIGIT_LIMIT < 10) ? DIGIT_LIMIT : 10;
         if (lim < 1) begin
            lim = 1;
         end
         n = 0;
         do begin
            digits.push_front(4'(rest % 10));
            rest = rest / 10;
            n++;
         end while (rest != 0 && n < lim);
         for (int k = 0; k < n; k++) begin
            d.digit_char = ASCII_ZERO + CHAR_W'(digits[k]);
            d.last_digit = (k == n - 1);
            pending_digits.push_back(d);
         end
         values_seen++;
         per_length[n]++;
      endtask

      task check_char(input logic [CHAR_W-1:0] ch, input logic last);
         ascii_digit_type want;
         chars_checked++;
         if (pending_digits.size() == 0) begin
            report($sformatf("unexpected character %0d (last %b)", ch, last));
         end else begin
            want = pending_digits.pop_front();
            if (ch !== want.digit_char) begin
               report($sformatf("digit_char %0d, expected %0d", ch, want.digit_char));
            end
            if (last !== want.last_digit) begin
               report($sformatf("last_digit %b, expected %b", last, want.last_digit));
            end
         end
      endtask
   endclass

   logic clock;
   logic reset;

   b2d_req_if req_chan ();
   b2d_rsp_if rsp_chan ();

   binary_to_decimal_ascii_core #(
      .MAX_DIGITS(DIGIT_LIMIT)
   ) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   decimal_scoreboard sb = new();
   logic [VALUE_W-1:0] stimulus[$];
   int idle_cycles = 0;
   bit hold_done = 0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Handshakes are sampled before the block's registers update at this edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            sb.note_value(req_chan.value);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            sb.check_char(rsp_chan.digit_char, rsp_chan.last_digit);
         end
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= MAX_IDLE) begin
            $display("Timeout: no word moved for %0d cycles, %0d digits still expected",
                     MAX_IDLE, sb.pending_digits.size());
            $display("*** FAILED ***");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Receiver: switches between stall patterns, and once holds off for a long
   // stretch so that the block fills up and closes its input.
   initial begin
      int mode;
      int span;
      int phase;
      rsp_chan.ready = 1'b0;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 96);
         repeat (span) begin
            @(negedge clock);
            if (!hold_done && sb.chars_checked >= HOLD_AFTER) begin
               hold_done = 1;
               rsp_chan.ready <= 1'b0;
               repeat (LONG_HOLD) @(negedge clock);
            end
            phase++;
            case (mode)
               0: begin
                  rsp_chan.ready <= 1'b1;
               end
               1: begin
                  rsp_chan.ready <= $urandom_range(0, 1);
               end
               2: begin
                  rsp_chan.ready <= (phase % 4) != 3;
               end
               default: begin
                  rsp_chan.ready <= ($urandom_range(0, 3) == 0);
               end
            endcase
         end
      end
   end

   task automatic drive_values();
      int burst_left;
      int gap;
      burst_left = $urandom_range(1, 8);
      while (stimulus.size() != 0) begin
         req_chan.valid <= 1'b1;
         req_chan.value <= stimulus[0];
         @(posedge clock);
         while (!req_chan.ready) @(posedge clock);
         void'(stimulus.pop_front());
         @(negedge clock);
         burst_left--;
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            if (gap != 0) begin
               req_chan.valid <= 1'b0;
               req_chan.value <= $urandom;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 8);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin
      int               pick;
      int               len;
      longint unsigned  lo;
      longint unsigned  hi;
      req_chan.valid = 1'b0;
      req_chan.value = '0;
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Zero, several digit-count boundaries, the largest word and bit patterns.
      stimulus = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
                   32'd12345, 32'd99999, 32'd100000, 32'd999999999, 32'd1000000000,
                   32'd1000000001, 32'd1234567890, 32'd2147483647, 32'd2147483648,
                   32'd4000000000, 32'd4294967294, 32'd4294967295,
                   32'hAAAA_AAAA, 32'h5555_5555};

      // Random part: mostly values of a chosen digit count so that every
      // length is well represented, plus small values and full-range words.
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0) begin
            stimulus.push_back($urandom_range(0, 20));
         end else if (pick <= 3) begin
            stimulus.push_back($urandom);
         end else begin
            len = $urandom_range(1, 10);
            lo = 1;
            repeat (len - 1) lo = lo * 10;
            hi = (len == 10) ? 64'hFFFF_FFFF : lo * 10 - 1;
            if (len == 1) begin
               lo = 0;
            end
            stimulus.push_back($urandom_range(32'(hi), 32'(lo)));
         end
      end

      drive_values();

      while (sb.pending_digits.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Converted %0d values into %0d characters with random stalls on both sides",
               sb.values_seen, sb.chars_checked);
      $display("Values by digit count 1..10: %0d %0d %0d %0d %0d %0d %0d %0d %0d %0d",
               sb.per_length[1], sb.per_length[2], sb.per_length[3], sb.per_length[4],
               sb.per_length[5], sb.per_length[6], sb.per_length[7], sb.per_length[8],
               sb.per_length[9], sb.per_length[10]);
      if (sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", sb.errors);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> binary_to_decimal_ascii_core.f
rtl/core/b2d_pkg.sv
rtl/core/b2d_if.sv
rtl/core/b2d_datapath.sv
rtl/core/b2d_ctrl.sv
rtl/core/binary_to_decimal_ascii_core.sv
dv/testbench.sv
